// File: hw/rtl/pac_pkg.sv
// Shared types, codes and sizes for the positional array list.
package pac_pkg;

	localparam int DEPTH   = 128;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int POS_W   = 7;
	localparam int COUNT_W = 8;
	localparam int GROUP   = 16;
	localparam int NGROUP  = (DEPTH + GROUP - 1) / GROUP;

	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_APPEND = 2'd2;
	localparam logic [1:0] KIND_DELETE = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_APPEND,
		CMD_DELETE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [CNT_W-1:0] pos;
		logic [CNT_W-1:0] used;
	} cell_cmd_t;

	typedef logic [DATA_W-1:0] word_t;

endpackage

// File: hw/rtl/pac_cell.sv
// One list cell: holds a single word and shifts it toward either neighbor.
module pac_cell (
	input  logic              clk,
	input  pac_pkg::cell_cmd_t cmd,
	input  pac_pkg::word_t    value,
	input  logic [pac_pkg::IDX_W-1:0] idx,
	input  pac_pkg::word_t    left,
	input  pac_pkg::word_t    right,
	output pac_pkg::word_t    entry,
	output pac_pkg::word_t    sel
);
	import pac_pkg::*;

	word_t            entry_q;
	logic [CNT_W-1:0] idx_c;

	assign idx_c = CNT_W'(idx);
	assign entry = entry_q;
	assign sel   = (idx_c == cmd.pos) ? entry_q : '0;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_INSERT: begin
				if (idx_c == cmd.pos) begin
					entry_q <= value;
				end else if (idx_c > cmd.pos) begin
					entry_q <= left;
				end
			end
			CMD_APPEND: begin
				if (idx_c == cmd.used) begin
					entry_q <= value;
				end
			end
			CMD_DELETE: begin
				if (idx_c >= cmd.pos) begin
					entry_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hw/rtl/pac_reduce.sv
// Registered two-level OR tree that gathers the selected cell word.
module pac_reduce (
	input  logic           clk,
	input  logic           load,
	input  pac_pkg::word_t sel [pac_pkg::DEPTH],
	output pac_pkg::word_t word_out
);
	import pac_pkg::*;

	word_t part_c [NGROUP];
	word_t part_s1 [NGROUP];

	always_comb begin
		for (int g = 0; g < NGROUP; g++) begin
			part_c[g] = '0;
			for (int j = 0; j < GROUP; j++) begin
				if (g * GROUP + j < DEPTH) begin
					part_c[g] = part_c[g] | sel[g * GROUP + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			part_s1 <= part_c;
		end
	end

	always_comb begin
		word_out = '0;
		for (int g = 0; g < NGROUP; g++) begin
			word_out = word_out | part_s1[g];
		end
	end

endmodule

// File: hw/rtl/positional_array_list.sv
// Top level of the positional array list: request decode, cell row and result register.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, kind, position,  | request
//          | value                                |
//  out     | out_valid, out_stall, data_out,      | result
//          | status, count, empty_res, full_res   |
//
// For every word any cell shift happens on the accepting edge, the tree register
// takes the gathered word on that same edge, and the result register follows.
// One word is in flight at a time, so in_stall is high until its result leaves.
// Reset clears the count and the valid flags; the cells themselves are not reset.
// A stalled result holds in its register.
module positional_array_list (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic [pac_pkg::POS_W-1:0]     position,
	input  logic signed [pac_pkg::DATA_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [pac_pkg::DATA_W-1:0] data_out,
	output logic [1:0]                    status,
	output logic [pac_pkg::COUNT_W-1:0]   count,
	output logic                          empty_res,
	output logic                          full_res
);
	import pac_pkg::*;

	logic             accept;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] used_n;
	logic [CNT_W-1:0] pos_c;
	logic             full_c;
	logic [1:0]       status_c;
	cmd_op_t          op_c;
	logic             take_c;
	cell_cmd_t        cmd;

	logic             valid_s1;
	logic [1:0]       status_s1;
	logic [CNT_W-1:0] used_s1;
	logic             take_s1;

	logic             out_valid_q;
	word_t            data_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] used_out_q;

	word_t entry_w [DEPTH];
	word_t sel_w [DEPTH];
	word_t gathered;

	assign in_stall = valid_s1 | out_valid_q;
	assign accept   = in_valid & ~in_stall;
	assign pos_c    = CNT_W'(position);
	assign full_c   = (used_q == CNT_W'(DEPTH));

	always_comb begin
		used_n   = used_q;
		status_c = ST_OK;
		op_c     = CMD_NONE;
		take_c   = 1'b0;
		case (kind)
			KIND_READ: begin
				if (pos_c < used_q) begin
					take_c = 1'b1;
				end else begin
					status_c = ST_RANGE;
				end
			end
			KIND_INSERT: begin
				if (full_c) begin
					status_c = ST_FULL;
				end else if (pos_c > used_q) begin
					status_c = ST_RANGE;
				end else begin
					op_c   = CMD_INSERT;
					used_n = used_q + 1'b1;
				end
			end
			KIND_APPEND: begin
				if (full_c) begin
					status_c = ST_FULL;
				end else begin
					op_c   = CMD_APPEND;
					used_n = used_q + 1'b1;
				end
			end
			KIND_DELETE: begin
				if (pos_c < used_q) begin
					take_c = 1'b1;
					op_c   = CMD_DELETE;
					used_n = used_q - 1'b1;
				end else begin
					status_c = ST_RANGE;
				end
			end
			default: begin
				status_c = ST_RANGE;
			end
		endcase
	end

	always_comb begin
		cmd.op   = accept ? op_c : CMD_NONE;
		cmd.pos  = pos_c;
		cmd.used = used_q;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end
		pac_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.value (word_t'(value)),
			.idx   (IDX_W'(i)),
			.left  (left_w),
			.right (right_w),
			.entry (entry_w[i]),
			.sel   (sel_w[i])
		);
	end

	pac_reduce u_reduce (
		.clk      (clk),
		.load     (accept),
		.sel      (sel_w),
		.word_out (gathered)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				used_q <= used_n;
			end
			if (valid_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_c;
			used_s1   <= used_n;
			take_s1   <= take_c;
		end
		if (valid_s1) begin
			data_q     <= take_s1 ? gathered : '0;
			status_q   <= status_s1;
			used_out_q <= used_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = $signed(data_q);
	assign status    = status_q;
	assign count     = COUNT_W'(used_out_q);
	assign empty_res = (used_out_q == '0);
	assign full_res  = (used_out_q == CNT_W'(DEPTH));

endmodule

// File: tb/positional_array_list_checker.sv
// Checker for the positional array list: predicts each result and compares it with the block.
module positional_array_list_checker
	import pac_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [POS_W-1:0]    position,
	input  logic [DATA_W-1:0]   value,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [DATA_W-1:0]   data_out,
	input  logic [1:0]          status,
	input  logic [COUNT_W-1:0]  count,
	input  logic                empty_res,
	input  logic                full_res,
	output int                  fail_count,
	output int                  outstanding,
	output int                  list_level
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		word_t              data;
		logic [1:0]         status;
		logic [COUNT_W-1:0] count;
		logic               empty;
		logic               full;
	} list_result_t;

	word_t        list_words [DEPTH];
	int           list_used = 0;
	int           errors = 0;
	list_result_t awaited [$];

	function automatic list_result_t apply_request(input logic [1:0] op,
		input logic [POS_W-1:0] pos, input word_t val);
		list_result_t r;
		int           p;
		int           i;
		p = pos;
		r.data = '0;
		r.status = ST_OK;
		case (op)
			KIND_READ: begin
				if (p < list_used) begin
					r.data = list_words[p];
				end else begin
					r.status = ST_RANGE;
				end
			end
			KIND_INSERT: begin
				if (list_used >= DEPTH) begin
					r.status = ST_FULL;
				end else if (p > list_used) begin
					r.status = ST_RANGE;
				end else begin
					for (i = list_used; i > p; i--)
						list_words[i] = list_words[i - 1];
					list_words[p] = val;
					list_used++;
				end
			end
			KIND_APPEND: begin
				if (list_used >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					list_words[list_used] = val;
					list_used++;
				end
			end
			default: begin
				if (p < list_used) begin
					r.data = list_words[p];
					for (i = p; i + 1 < list_used; i++)
						list_words[i] = list_words[i + 1];
					list_used--;
				end else begin
					r.status = ST_RANGE;
				end
			end
		endcase
		r.count = list_used[COUNT_W-1:0];
		r.empty = (list_used == 0);
		r.full = (list_used == DEPTH);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			list_used = 0;
			awaited.delete();
			fail_count <= errors;
			outstanding <= 0;
			list_level <= 0;
		end else begin
			if (in_valid && !in_stall)
				awaited.push_back(apply_request(kind, position, value));
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					$display("%0t: result with none expected, data_out %0h status %0h count %0h",
						$time, data_out, status, count);
					errors++;
				end else begin
					want = awaited.pop_front();
					check_field("data_out", want.data, data_out);
					check_field("status", DATA_W'(want.status), DATA_W'(status));
					check_field("count", DATA_W'(want.count), DATA_W'(count));
					check_field("empty_res", DATA_W'(want.empty), DATA_W'(empty_res));
					check_field("full_res", DATA_W'(want.full), DATA_W'(full_res));
				end
			end
			fail_count <= errors;
			outstanding <= awaited.size();
			list_level <= list_used;
		end
	end

endmodule

// File: tb/tb_positional_array_list.sv
// Testbench top for the positional array list: clock, reset, request stimulus and verdict.
module tb_positional_array_list;
	timeunit 1ns;
	timeprecision 1ps;
	import pac_pkg::*;

	localparam int WORDS_PER_PHASE = 290;
	localparam int CYCLE_LIMIT = 200000;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [1:0]                kind;
	logic [POS_W-1:0]          position;
	logic signed [DATA_W-1:0]  value;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [DATA_W-1:0]  data_out;
	logic [1:0]                status;
	logic [COUNT_W-1:0]        count;
	logic                      empty_res;
	logic                      full_res;

	int fail_count;
	int outstanding;
	int list_level;
	int cycles = 0;
	int stall_pct = 0;
	int send_idle = 0;
	bit growing = 1'b1;

	positional_array_list uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out),
		.status(status),
		.count(count),
		.empty_res(empty_res),
		.full_res(full_res)
	);

	positional_array_list_checker list_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out),
		.status(status),
		.count(count),
		.empty_res(empty_res),
		.full_res(full_res),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.list_level(list_level)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	task automatic send_word(input logic [1:0] k, input logic [POS_W-1:0] p, input word_t v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		position <= p;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic random_word();
		logic [1:0] k;
		int         p;
		int         lvl;
		int         roll;
		word_t      v;
		lvl = list_level;
		if (growing && lvl >= DEPTH && $urandom_range(3) == 0)
			growing = 1'b0;
		else if (!growing && lvl == 0 && $urandom_range(3) == 0)
			growing = 1'b1;
		roll = $urandom_range(99);
		if (growing)
			k = roll < 45 ? KIND_APPEND : roll < 80 ? KIND_INSERT :
				roll < 90 ? KIND_READ : KIND_DELETE;
		else
			k = roll < 55 ? KIND_DELETE : roll < 80 ? KIND_READ :
				roll < 90 ? KIND_INSERT : KIND_APPEND;
		if ($urandom_range(9) == 0) begin
			k = 2'($urandom_range(3));
			p = $urandom_range(127);
		end else if (k == KIND_INSERT) begin
			p = $urandom_range(lvl > 127 ? 127 : lvl);
		end else begin
			p = lvl > 0 ? $urandom_range(lvl - 1) : 0;
		end
		case ($urandom_range(7))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = '1;
			3: v = '0;
			default: v = $urandom();
		endcase
		send_word(k, p[POS_W-1:0], v);
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_READ;
		position = '0;
		value = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(KIND_READ, 7'd0, 32'h0);
		send_word(KIND_DELETE, 7'd0, 32'h0);
		send_word(KIND_DELETE, 7'd127, 32'hffff_ffff);
		send_word(KIND_INSERT, 7'd1, 32'h1234_5678);
		send_word(KIND_INSERT, 7'd0, 32'h8000_0000);
		send_word(KIND_APPEND, 7'd127, 32'h7fff_ffff);
		send_word(KIND_APPEND, 7'd0, 32'h0);
		send_word(KIND_APPEND, 7'd0, 32'hffff_ffff);
		send_word(KIND_INSERT, 7'd2, 32'h0000_0005);
		send_word(KIND_INSERT, 7'd5, 32'h5555_5555);
		send_word(KIND_INSERT, 7'd7, 32'haaaa_aaaa);
		send_word(KIND_READ, 7'd0, 32'h0);
		send_word(KIND_READ, 7'd5, 32'h0);
		send_word(KIND_READ, 7'd6, 32'h0);
		send_word(KIND_READ, 7'd127, 32'h0);
		send_word(KIND_DELETE, 7'd5, 32'h0);
		send_word(KIND_DELETE, 7'd0, 32'h0);
		send_word(KIND_DELETE, 7'd2, 32'h0);
		send_word(KIND_DELETE, 7'd3, 32'h0);
		send_word(KIND_READ, 7'd2, 32'h0);
		drain_results();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle = 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle = 72;
					stall_pct <= 0;
				end
				2: begin
					send_idle = 0;
					stall_pct <= 72;
				end
				default: begin
					send_idle = 32;
					stall_pct <= 32;
				end
			endcase
			repeat (WORDS_PER_PHASE)
				random_word();
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/pac_pkg.sv
hw/rtl/pac_cell.sv
hw/rtl/pac_reduce.sv
hw/rtl/positional_array_list.sv
tb/positional_array_list_checker.sv
tb/tb_positional_array_list.sv
